// ===== sv/pixel_contour_corner_walker_core_assert.svh =====
// Assertion macros for the contour corner walker.
// Each expects clk_i and rst_ni in scope.
`ifndef PIXEL_CONTOUR_CORNER_WALKER_CORE_ASSERT_SVH
`define PIXEL_CONTOUR_CORNER_WALKER_CORE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PCCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define PCCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/pccw_pkg.sv =====
// ----------------------------------------------------------------------------
// pccw_pkg
// Corner codes, sequencer states and corner helpers for the corner walker.
// ----------------------------------------------------------------------------
package pccw_pkg;

  // corner codes, rolled NW -> SW -> SE -> NE -> NW
  localparam logic [1:0] CORNER_NW = 2'd0;
  localparam logic [1:0] CORNER_SW = 2'd1;
  localparam logic [1:0] CORNER_SE = 2'd2;
  localparam logic [1:0] CORNER_NE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIR   = 4'b0010,
    ST_ROLL  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  // corner lies on the east side of its pixel
  function automatic logic corner_east(input logic [1:0] c);
    return (c == CORNER_SE) || (c == CORNER_NE);
  endfunction

  // corner lies on the south side of its pixel
  function automatic logic corner_south(input logic [1:0] c);
    return (c == CORNER_SW) || (c == CORNER_SE);
  endfunction

endpackage

// ===== sv/pixel_contour_corner_walker_core.sv =====
// ----------------------------------------------------------------------------
// pixel_contour_corner_walker_core
// Walks pixel corners along a contour pixel chain and emits polygon vertices.
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+--------------------------------------
//  in      | in_valid_i  | in_stall_o   | first_pixel_i pixel_x_i pixel_y_i is_hole_i
//  out     | out_valid_o | out_stall_i  | corner_x_o corner_y_o ring_closed_o
//
//  A first pixel, or a pixel arriving after the walk closed, is taken in idle alone.
//  Any other pixel goes through accept, direction, one to four corner rolls
//  through the shared roll unit (one roll per cycle unless stalled), and flush.
//  A held output beat stalls a roll or the flush that must push a vertex
//  until the beat leaves.
//  Reset (async, active low) leaves the walk closed: idle until a first pixel.
//  in_stall_o is high whenever the sequencer is busy with a pixel.
//
module pixel_contour_corner_walker_core
  import pccw_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  first_pixel_i,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic                  is_hole_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS:0]   corner_x_o,
  output logic [COORD_BITS:0]   corner_y_o,
  output logic                  ring_closed_o
);

`include "pixel_contour_corner_walker_core_assert.svh"

  localparam int VW = COORD_BITS + 1;

  // sequencer
  state_e state_q, state_d;
  logic [1:0] roll_q, roll_d;

  // walker state
  logic [COORD_BITS-1:0] walk_x_q, walk_x_d, walk_y_q, walk_y_d;
  logic [1:0]            corner_q, corner_d;
  logic [VW-1:0]         start_x_q, start_x_d, start_y_q, start_y_d;
  logic [VW-1:0]         last_x_q, last_x_d, last_y_q, last_y_d;
  logic                  have_q, have_d;
  logic                  done_q, done_d;

  // per-pixel work registers
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic                  same_q, same_d;
  logic                  sxp_q, sxp_d, sxn_q, sxn_d, syp_q, syp_d, syn_q, syn_d;
  logic                  closed_q, closed_d;
  // last_x/last_y hold a vertex that is not yet pushed out: its flag is unknown
  logic                  pend_q, pend_d;

  // output register
  logic          oval_q, oval_d;
  logic [VW-1:0] ox_q, ox_d, oy_q, oy_d;
  logic          oclose_q, oclose_d;

  logic in_acc;
  logic out_free;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_free      = !oval_q || !out_stall_i;
  assign out_valid_o   = oval_q;
  assign corner_x_o    = ox_q;
  assign corner_y_o    = oy_q;
  assign ring_closed_o = oclose_q;

  // direction unit: step to the pixel reduced to its dominant axis signs
  logic [VW-1:0] dx, dy, ax, ay, mx;

  always_comb begin
    dx = {1'b0, px_q} - {1'b0, walk_x_q};
    dy = {1'b0, py_q} - {1'b0, walk_y_q};
    ax = dx[VW-1] ? (~dx + VW'(1)) : dx;
    ay = dy[VW-1] ? (~dy + VW'(1)) : dy;
    mx = (ax > ay) ? ax : ay;
  end

  // roll unit
  logic          c_east, c_south, n_east, n_south;
  logic [VW-1:0] vx, vy, nvx, nvy, st_x, st_y;
  logic          need_emit, ok_x, ok_y, take, straight, close_now, roll_stall;
  logic [1:0]    c_tmp, c_new;
  logic [COORD_BITS-1:0] wx_new, wy_new;

  always_comb begin
    c_east    = corner_east(corner_q);
    c_south   = corner_south(corner_q);
    vx        = {1'b0, walk_x_q} + VW'(c_east);
    vy        = {1'b0, walk_y_q} + VW'(c_south);
    need_emit = !have_q || (vx != last_x_q) || (vy != last_y_q);
    // a nonzero sign asks for the corner on that side of the walker's pixel
    ok_x      = !(sxp_q && !c_east) && !(sxn_q && c_east);
    ok_y      = !(syp_q && !c_south) && !(syn_q && c_south);
    take      = !same_q && ok_x && ok_y;
    straight  = !(sxp_q || sxn_q) || !(syp_q || syn_q);
    c_tmp     = take ? (corner_q + 2'd2 + {1'b0, straight}) : corner_q;
    c_new     = c_tmp + 2'd1;
    wx_new    = take ? px_q : walk_x_q;
    wy_new    = take ? py_q : walk_y_q;
    n_east    = corner_east(c_new);
    n_south   = corner_south(c_new);
    nvx       = {1'b0, wx_new} + VW'(n_east);
    nvy       = {1'b0, wy_new} + VW'(n_south);
    st_x      = have_q ? start_x_q : vx;
    st_y      = have_q ? start_y_q : vy;
    close_now = (nvx == st_x) && (nvy == st_y);
    // a fresh vertex displaces the pending one, which needs a free output
    roll_stall = need_emit && pend_q && !out_free;
  end

  always_comb begin
    state_d   = state_q;
    roll_d    = roll_q;
    walk_x_d  = walk_x_q;
    walk_y_d  = walk_y_q;
    corner_d  = corner_q;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    last_x_d  = last_x_q;
    last_y_d  = last_y_q;
    have_d    = have_q;
    done_d    = done_q;
    px_d      = px_q;
    py_d      = py_q;
    same_d    = same_q;
    sxp_d     = sxp_q;
    sxn_d     = sxn_q;
    syp_d     = syp_q;
    syn_d     = syn_q;
    closed_d  = closed_q;
    pend_d    = pend_q;
    oval_d    = oval_q && out_stall_i;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oclose_d  = oclose_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (first_pixel_i) begin
            // restart: place walker, no vertex yet
            walk_x_d = pixel_x_i;
            walk_y_d = pixel_y_i;
            corner_d = is_hole_i ? CORNER_SW : CORNER_NW;
            have_d   = 1'b0;
            done_d   = 1'b0;
          end else if (!done_q) begin
            px_d    = pixel_x_i;
            py_d    = pixel_y_i;
            state_d = ST_DIR;
          end
        end
      end
      ST_DIR: begin
        same_d   = (px_q == walk_x_q) && (py_q == walk_y_q);
        sxp_d    = (ax == mx) && (mx != '0) && !dx[VW-1];
        sxn_d    = (ax == mx) && (mx != '0) && dx[VW-1];
        syp_d    = (ay == mx) && (mx != '0) && !dy[VW-1];
        syn_d    = (ay == mx) && (mx != '0) && dy[VW-1];
        roll_d   = 2'd0;
        closed_d = 1'b0;
        pend_d   = 1'b0;
        state_d  = ST_ROLL;
      end
      ST_ROLL: begin
        if (!roll_stall) begin
          if (need_emit) begin
            if (pend_q) begin
              oval_d   = 1'b1;
              ox_d     = last_x_q;
              oy_d     = last_y_q;
              oclose_d = 1'b0;
            end
            pend_d   = 1'b1;
            last_x_d = vx;
            last_y_d = vy;
            if (!have_q) begin
              start_x_d = vx;
              start_y_d = vy;
              have_d    = 1'b1;
            end
          end
          walk_x_d = wx_new;
          walk_y_d = wy_new;
          corner_d = c_new;
          closed_d = close_now;
          roll_d   = roll_q + 2'd1;
          if (close_now || take || (roll_q == 2'd3)) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        // pending vertex (or a repeat of the last one on a bare close) goes out
        if (!((pend_q || closed_q) && !out_free)) begin
          if (pend_q || closed_q) begin
            oval_d   = 1'b1;
            ox_d     = last_x_q;
            oy_d     = last_y_q;
            oclose_d = closed_q;
          end
          pend_d  = 1'b0;
          done_d  = closed_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      roll_q    <= 2'd0;
      walk_x_q  <= '0;
      walk_y_q  <= '0;
      corner_q  <= CORNER_NW;
      start_x_q <= '0;
      start_y_q <= '0;
      last_x_q  <= '0;
      last_y_q  <= '0;
      have_q    <= 1'b0;
      done_q    <= 1'b1;
      closed_q  <= 1'b0;
      pend_q    <= 1'b0;
      oval_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      roll_q    <= roll_d;
      walk_x_q  <= walk_x_d;
      walk_y_q  <= walk_y_d;
      corner_q  <= corner_d;
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      last_x_q  <= last_x_d;
      last_y_q  <= last_y_d;
      have_q    <= have_d;
      done_q    <= done_d;
      closed_q  <= closed_d;
      pend_q    <= pend_d;
      oval_q    <= oval_d;
    end
  end

  // payload and the per-pixel position, match and sign registers, no reset
  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    same_q   <= same_d;
    sxp_q    <= sxp_d;
    sxn_q    <= sxn_d;
    syp_q    <= syp_d;
    syn_q    <= syn_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    oclose_q <= oclose_d;
  end

  // ---------------------------------------------------------------- checks
  `PCCW_ASSERT(a_busy_walk_open,
               (state_q == ST_ROLL || state_q == ST_FLUSH) |-> !done_q,
               "busy on a closed walk")
  `PCCW_ASSERT(a_pend_has_vertex, pend_q |-> have_q,
               "pending vertex without a start vertex")
  `PCCW_ASSERT(a_roll_limit,
               (state_q == ST_ROLL && roll_q == 2'd3 && !roll_stall) |=> (state_q == ST_FLUSH),
               "more than four rolls")
  `PCCW_ASSERT(a_close_ends_walk,
               (state_q == ST_FLUSH && closed_q && out_free)
                 |=> (done_q && out_valid_o && ring_closed_o),
               "close beat not issued")

endmodule
